[rtl/sbc_pkg.sv]
// ============================================================================
// sbc_pkg
// Shared constants, types and helper functions of the sector block cache
// tag store.
// ============================================================================
package sbc_pkg;

    localparam int INDEX_BITS    = 12;
    localparam int BLOCK_SECTORS = 16;
    localparam int ENTRIES       = 1 << INDEX_BITS;

    localparam int SECTOR_W  = 24;
    localparam int POS_W     = $clog2(BLOCK_SECTORS);
    localparam int BLOCK_W   = SECTOR_W - POS_W;
    localparam int OFFSET_W  = 16;
    localparam int OP_W      = 2;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;

    localparam int NSLICES   = (SECTOR_W + INDEX_BITS - 1) / INDEX_BITS;
    localparam int FOLD_W    = NSLICES * INDEX_BITS;

    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 2;

    // Register addresses
    localparam logic [PADDR_W-1:0] ADDR_SECTOR_COUNT = 2'd0;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_INVAL  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // Read modes
    localparam logic [MODE_W-1:0] MODE_RAW  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_2340 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_2328 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_2048 = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BEYOND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_INVAL  = 2'd2;

    localparam logic [OFFSET_W-1:0] RAW_BYTES   = 16'd2352;
    localparam logic [OFFSET_W-1:0] HDR_2340    = 16'd12;
    localparam logic [OFFSET_W-1:0] HDR_2328    = 16'd24;
    localparam int                  USER_SHIFT  = 11;

    typedef struct packed {
        logic              valid;
        logic [MODE_W-1:0] mode;
        logic [BLOCK_W-1:0] blk;
    } t_tag;

    // XOR of all INDEX_BITS-wide slices of the aligned sector, then the mode
    function automatic logic [INDEX_BITS-1:0] fold_index(
        input logic [SECTOR_W-1:0] aligned,
        input logic [MODE_W-1:0]   mode
    );
        logic [FOLD_W-1:0]     v;
        logic [INDEX_BITS-1:0] acc;
        v   = FOLD_W'(aligned);
        acc = '0;
        for (int k = 0; k < NSLICES; k++) begin
            acc = acc ^ v[k*INDEX_BITS +: INDEX_BITS];
        end
        return acc ^ INDEX_BITS'(mode);
    endfunction

    function automatic logic [OFFSET_W-1:0] block_offset(
        input logic [POS_W-1:0]  pos,
        input logic [MODE_W-1:0] mode
    );
        logic [OFFSET_W-1:0] raw;
        logic [OFFSET_W-1:0] res;
        raw = OFFSET_W'(pos) * RAW_BYTES;
        case (mode)
            MODE_2048: res = OFFSET_W'(pos) << USER_SHIFT;
            MODE_2328: res = raw + HDR_2328;
            MODE_2340: res = raw + HDR_2340;
            MODE_RAW:  res = raw;
            default:   res = raw;
        endcase
        return res;
    endfunction

endpackage

[rtl/sbc_req_if.sv]
// ============================================================================
// sbc_req_if
// Request channel of the tag store: valid/ready handshake and request fields.
// ============================================================================
interface sbc_req_if;
    import sbc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [SECTOR_W-1:0] sector;
    logic [MODE_W-1:0]   read_mode;

    modport source (output valid, output op, output sector, output read_mode,
                    input ready);
    modport sink   (input valid, input op, input sector, input read_mode,
                    output ready);
endinterface

[rtl/sbc_rsp_if.sv]
// ============================================================================
// sbc_rsp_if
// Result channel of the tag store: valid/ready handshake and result fields.
// ============================================================================
interface sbc_rsp_if;
    import sbc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic                  hit;
    logic [INDEX_BITS-1:0] entry_index;
    logic [SECTOR_W-1:0]   block_start;
    logic [OFFSET_W-1:0]   byte_offset;

    modport source (output valid, output status, output hit, output entry_index,
                    output block_start, output byte_offset, input ready);
    modport sink   (input valid, input status, input hit, input entry_index,
                    input block_start, input byte_offset, output ready);
endinterface

[rtl/sector_block_cache_tag_store_top.sv]
// ============================================================================
// sector_block_cache_tag_store_top
// Tag store of a direct-mapped cache of 16-sector disc blocks.
// ============================================================================
// Usage:
//   i_req carries one request beat (op, sector, read_mode); o_rsp returns one
//   result beat for lookup, update and invalidate. Op 3 is dropped and gives
//   no result. The APB port holds sector_count at address 0.
//   Tags live in one single-port synchronous RAM (valid, mode, block number).
//   Lookup and update do the RAM read or write in the accept cycle; ST_RESP
//   then compares and loads the output register once that register is free.
//   One request is in flight at a time.
//   Invalidate clears every RAM entry, one entry a cycle, and then gives
//   its result through ST_RESP.
//   After reset the same sweep runs with i_req.ready low and no result;
//   sector_count resets to zero and APB writes are taken throughout.
//   A stalled result waits in the output register; a new request is accepted
//   meanwhile, and its result waits until the held beat is taken.
// ============================================================================
module sector_block_cache_tag_store_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbc_pkg::PADDR_W-1:0]   paddr,
    input  logic [sbc_pkg::PDATA_W-1:0]   pwdata,
    output logic [sbc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    sbc_req_if.sink                       i_req,
    sbc_rsp_if.source                     o_rsp
);
    import sbc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RESP  = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [INDEX_BITS-1:0] r_clr_cnt, n_clr_cnt;
    logic                  r_clr_reply;
    logic [SECTOR_W-1:0]   r_sector_count;

    logic [OP_W-1:0]       r_op;
    logic [SECTOR_W-1:0]   r_sector;
    logic [MODE_W-1:0]     r_mode;
    logic [INDEX_BITS-1:0] r_idx;

    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic                  r_out_hit;
    logic [INDEX_BITS-1:0] r_out_idx;
    logic [SECTOR_W-1:0]   r_out_start;
    logic [OFFSET_W-1:0]   r_out_offset;

    t_tag                  r_mem [ENTRIES];
    t_tag                  r_rdata;
    logic                  mem_we;
    logic                  mem_re;
    logic [INDEX_BITS-1:0] mem_addr;
    t_tag                  mem_wdata;

    logic                  accept;
    logic [SECTOR_W-1:0]   in_aligned;
    logic [INDEX_BITS-1:0] in_idx;
    logic                  slot_free;
    logic [SECTOR_W-1:0]   cmp_aligned;
    logic                  beyond;
    logic                  tag_hit;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SECTOR_COUNT) ? PDATA_W'(r_sector_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_count <= '0;
        end else if (psel && penable && pwrite && pready) begin
            r_sector_count <= pwdata[SECTOR_W-1:0];
        end
    end

    // ---------------- request side ----------------
    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign in_aligned  = {i_req.sector[SECTOR_W-1:POS_W], POS_W'(0)};
    assign in_idx      = fold_index(in_aligned, i_req.read_mode);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_req.op;
            r_sector <= i_req.sector;
            r_mode   <= i_req.read_mode;
            r_idx    <= in_idx;
        end
    end

    // ---------------- tag RAM ----------------
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = in_idx;
        mem_wdata = '0;
        if (r_state == ST_CLEAR) begin
            mem_we   = 1'b1;
            mem_addr = r_clr_cnt;
        end else if (accept && i_req.op == OP_UPDATE) begin
            mem_we          = 1'b1;
            mem_wdata.valid = 1'b1;
            mem_wdata.mode  = i_req.read_mode;
            mem_wdata.blk   = i_req.sector[SECTOR_W-1:POS_W];
        end else if (accept && i_req.op == OP_LOOKUP) begin
            mem_re = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    // ---------------- control ----------------
    assign slot_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req.op)
                        OP_LOOKUP: n_state = ST_RESP;
                        OP_UPDATE: n_state = ST_RESP;
                        OP_INVAL: begin
                            n_state   = ST_CLEAR;
                            n_clr_cnt = '0;
                        end
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RESP: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (&r_clr_cnt) begin
                    n_state = r_clr_reply ? ST_RESP : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_clr_reply <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            if (accept && i_req.op == OP_INVAL) begin
                r_clr_reply <= 1'b1;
            end
        end
    end

    // ---------------- compare and result ----------------
    assign cmp_aligned = {r_sector[SECTOR_W-1:POS_W], POS_W'(0)};
    assign beyond      = (r_sector >= r_sector_count);
    assign tag_hit     = r_rdata.valid && (r_rdata.blk == r_sector[SECTOR_W-1:POS_W])
                         && (r_rdata.mode == r_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_RESP && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESP && slot_free) begin
            r_out_status <= STAT_DONE;
            r_out_hit    <= 1'b0;
            r_out_idx    <= '0;
            r_out_start  <= '0;
            r_out_offset <= '0;
            case (r_op)
                OP_LOOKUP: begin
                    if (beyond) begin
                        r_out_status <= STAT_BEYOND;
                    end else begin
                        r_out_hit    <= tag_hit;
                        r_out_idx    <= r_idx;
                        r_out_start  <= cmp_aligned;
                        r_out_offset <= block_offset(r_sector[POS_W-1:0], r_mode);
                    end
                end
                OP_UPDATE: begin
                    r_out_idx   <= r_idx;
                    r_out_start <= cmp_aligned;
                end
                OP_INVAL: r_out_status <= STAT_INVAL;
                default:  r_out_status <= STAT_DONE;
            endcase
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.entry_index = r_out_idx;
    assign o_rsp.block_start = r_out_start;
    assign o_rsp.byte_offset = r_out_offset;

endmodule

[rtl/sbc_checker.sv]
// ============================================================================
// sbc_checker
// Port-level checks of the tag store, bound to the top level.
// ============================================================================
module sbc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_req_valid,
    input logic                            i_req_ready,
    input logic [sbc_pkg::OP_W-1:0]        i_req_op,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input logic [sbc_pkg::STATUS_W-1:0]    i_rsp_status,
    input logic                            i_rsp_hit,
    input logic [sbc_pkg::INDEX_BITS-1:0]  i_rsp_entry_index,
    input logic [sbc_pkg::SECTOR_W-1:0]    i_rsp_block_start,
    input logic [sbc_pkg::OFFSET_W-1:0]    i_rsp_byte_offset
);
    import sbc_pkg::*;

    // A held result beat stays valid
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result beat dropped while stalled");

    // A held result beat keeps its payload
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            $stable(i_rsp_status) && $stable(i_rsp_hit) && $stable(i_rsp_entry_index)
            && $stable(i_rsp_block_start) && $stable(i_rsp_byte_offset))
        else $error("stalled result beat changed");

    // One request in flight: an accepted op that gives a result blocks the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_op != OP_NONE |=> !i_req_ready)
        else $error("request accepted while one is in flight");

    // Out-of-range lookups and invalidates report all-zero fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == STAT_BEYOND || i_rsp_status == STAT_INVAL) |->
            !i_rsp_hit && i_rsp_entry_index == '0 && i_rsp_block_start == '0
            && i_rsp_byte_offset == '0)
        else $error("nonzero fields on beyond-end or invalidate result");

    // Block start is always aligned to a block boundary
    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_block_start[POS_W-1:0] == '0)
        else $error("block_start not block aligned");

endmodule

bind sector_block_cache_tag_store_top sbc_checker u_sbc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_req_op          (i_req.op),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_hit         (o_rsp.hit),
    .i_rsp_entry_index (o_rsp.entry_index),
    .i_rsp_block_start (o_rsp.block_start),
    .i_rsp_byte_offset (o_rsp.byte_offset)
);

[tb/sv/tb_sector_block_cache_tag_store_top.sv]
// ----------------------------------------------------------------------------
// tb_sector_block_cache_tag_store_top
// Self-checking bench for the sector block cache tag store. A local tag
// array predicts every result beat: hit or miss, folded entry index, block
// start and byte offset. Directed cases come first, then random traffic
// biased toward blocks that were recently tagged. Both sides idle at random,
// and sector_count is reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module tb_sector_block_cache_tag_store_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sbc_pkg::*;

    localparam int REG_SECTOR_COUNT = 0;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int POOL_DEPTH       = 32;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic                  hit;
        logic [INDEX_BITS-1:0] entry_index;
        logic [SECTOR_W-1:0]   block_start;
        logic [OFFSET_W-1:0]   byte_offset;
    } t_tag_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    sbc_req_if req_if ();
    sbc_rsp_if rsp_if ();

    sector_block_cache_tag_store_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow of the tag RAM and the sector_count register
    logic [BLOCK_W-1:0] shadow_blk   [ENTRIES];
    logic [MODE_W-1:0]  shadow_mode  [ENTRIES];
    bit                 shadow_valid [ENTRIES];
    logic [SECTOR_W-1:0] disc_sectors;

    t_tag_result                  pending_results[$];
    logic [SECTOR_W+MODE_W-1:0]   tagged_blocks[$];

    bit idle_on;
    int hold_left;
    int fail_count;
    int cycle_count;
    int accepted_items;
    int inval_budget;
    int n_lookup, n_hit, n_update, n_inval, n_beyond, n_checked;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_tag_result predict_request(
        input logic [OP_W-1:0]     op,
        input logic [SECTOR_W-1:0] sec,
        input logic [MODE_W-1:0]   mode
    );
        t_tag_result           r;
        logic [SECTOR_W-1:0]   aligned;
        logic [INDEX_BITS-1:0] idx;
        logic [BLOCK_W-1:0]    blk;
        logic [OFFSET_W-1:0]   pos;
        r       = '0;
        aligned = sec & ~SECTOR_W'(BLOCK_SECTORS - 1);
        blk     = BLOCK_W'(aligned >> POS_W);
        pos     = OFFSET_W'(sec[POS_W-1:0]);
        idx     = INDEX_BITS'(mode);
        for (int k = 0; k < SECTOR_W; k += INDEX_BITS) begin
            idx = idx ^ INDEX_BITS'(aligned >> k);
        end
        case (op)
            OP_LOOKUP: begin
                n_lookup++;
                if (sec >= disc_sectors) begin
                    r.status = STAT_BEYOND;
                    n_beyond++;
                end else begin
                    r.status      = STAT_DONE;
                    r.hit         = shadow_valid[idx] && shadow_blk[idx] == blk &&
                                    shadow_mode[idx] == mode;
                    r.entry_index = idx;
                    r.block_start = aligned;
                    case (mode)
                        MODE_2048: r.byte_offset = pos * 16'd2048;
                        MODE_2328: r.byte_offset = pos * 16'd2352 + 16'd24;
                        MODE_2340: r.byte_offset = pos * 16'd2352 + 16'd12;
                        default:   r.byte_offset = pos * 16'd2352;
                    endcase
                    if (r.hit) n_hit++;
                end
            end
            OP_UPDATE: begin
                n_update++;
                shadow_blk[idx]   = blk;
                shadow_mode[idx]  = mode;
                shadow_valid[idx] = 1'b1;
                r.status          = STAT_DONE;
                r.entry_index     = idx;
                r.block_start     = aligned;
            end
            default: begin
                n_inval++;
                for (int e = 0; e < ENTRIES; e++) shadow_valid[e] = 1'b0;
                r.status = STAT_INVAL;
            end
        endcase
        return r;
    endfunction

    // Offer one request beat; returns at the edge where it is taken
    task automatic send_item(
        input logic [OP_W-1:0]     op,
        input logic [SECTOR_W-1:0] sec,
        input logic [MODE_W-1:0]   mode
    );
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < 6) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid     = 1'b1;
        req_if.op        = op;
        req_if.sector    = sec;
        req_if.read_mode = mode;
        do @(posedge i_clk); while (!req_if.ready);
        if (op != OP_NONE) begin
            pending_results.push_back(predict_request(op, sec, mode));
            accepted_items++;
        end
    endtask

    task automatic drop_req();
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sector_count(input logic [SECTOR_W-1:0] value);
        drop_req();
        wait_drain();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(4 * REG_SECTOR_COUNT);
        pwdata  = PDATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        disc_sectors = value;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_random_item(input bit allow_inval);
        int                         r;
        logic [OP_W-1:0]            op;
        logic [SECTOR_W-1:0]        sec;
        logic [MODE_W-1:0]          mode;
        logic [MODE_W-1:0]          delta;
        logic [SECTOR_W+MODE_W-1:0] ent;
        r    = $urandom_range(99);
        sec  = SECTOR_W'($urandom);
        mode = MODE_W'($urandom_range(3));
        if (disc_sectors != 0 && $urandom_range(1) == 1)
            sec = SECTOR_W'($urandom_range(int'(disc_sectors) - 1, 0));
        if (r < 2 && allow_inval && inval_budget > 0) begin
            op = OP_INVAL;
            inval_budget--;
        end else if (r < 6) begin
            op = OP_NONE;
        end else if (r < 40) begin
            op = OP_UPDATE;
            if (tagged_blocks.size() != 0 && $urandom_range(99) < 40) begin
                ent = tagged_blocks[$urandom_range(tagged_blocks.size() - 1)];
                if ($urandom_range(1) == 1) begin
                    // same entry index, different block and mode: evicts
                    delta = MODE_W'($urandom_range(3, 1));
                    sec   = ent[SECTOR_W-1:0] ^ (SECTOR_W'(delta) << INDEX_BITS);
                    mode  = ent[SECTOR_W+:MODE_W] ^ delta;
                end else begin
                    sec = {ent[SECTOR_W-1:POS_W], POS_W'($urandom)};
                end
            end
            tagged_blocks.push_back({mode, sec & ~SECTOR_W'(BLOCK_SECTORS - 1)});
            if (tagged_blocks.size() > POOL_DEPTH) void'(tagged_blocks.pop_front());
        end else begin
            op = OP_LOOKUP;
            if (tagged_blocks.size() != 0 && $urandom_range(99) < 65) begin
                ent = tagged_blocks[$urandom_range(tagged_blocks.size() - 1)];
                sec = {ent[SECTOR_W-1:POS_W], POS_W'($urandom)};
                if ($urandom_range(99) < 80) mode = ent[SECTOR_W+:MODE_W];
            end
        end
        send_item(op, sec, mode);
    endtask

    task automatic run_random(input int count, input bit allow_inval);
        int target;
        target = accepted_items + count;
        while (accepted_items < target) send_random_item(allow_inval);
    endtask

    // sector_count is zero out of reset: every lookup is past the disc end
    task automatic test_beyond_at_zero_count();
        send_item(OP_LOOKUP, 24'h000000, MODE_RAW);
        send_item(OP_LOOKUP, 24'hFFFFFF, MODE_2048);
        send_item(OP_UPDATE, 24'h000000, MODE_RAW);
        write_sector_count(24'hFFFFFF);
    endtask

    task automatic test_offsets_and_hits();
        send_item(OP_LOOKUP, 24'h000000, MODE_RAW);
        send_item(OP_UPDATE, 24'h000005, MODE_RAW);
        send_item(OP_LOOKUP, 24'h00000F, MODE_RAW);
        send_item(OP_LOOKUP, 24'h00000F, MODE_2048);
        send_item(OP_UPDATE, 24'h00001F, MODE_2048);
        send_item(OP_LOOKUP, 24'h00001F, MODE_2048);
        send_item(OP_UPDATE, 24'h00002F, MODE_2328);
        send_item(OP_LOOKUP, 24'h00002F, MODE_2328);
        send_item(OP_UPDATE, 24'h000030, MODE_2340);
        send_item(OP_LOOKUP, 24'h000030, MODE_2340);
    endtask

    task automatic test_disc_end();
        send_item(OP_LOOKUP, 24'hFFFFFF, MODE_2048);
        send_item(OP_LOOKUP, 24'hFFFFFE, MODE_RAW);
        send_item(OP_UPDATE, 24'hFFFFFF, MODE_2048);
        send_item(OP_LOOKUP, 24'hFFFFF0, MODE_2048);
    endtask

    task automatic test_index_collision();
        send_item(OP_UPDATE, 24'h000100, MODE_RAW);
        send_item(OP_UPDATE, 24'h001100, MODE_2340);
        send_item(OP_LOOKUP, 24'h000100, MODE_RAW);
        send_item(OP_LOOKUP, 24'h001105, MODE_2340);
    endtask

    task automatic test_invalidate_and_ignored_op();
        send_item(OP_INVAL, 24'hABCDEF, MODE_2328);
        send_item(OP_LOOKUP, 24'h00001F, MODE_2048);
        send_item(OP_UPDATE, 24'h000040, MODE_RAW);
        send_item(OP_NONE, 24'h000040, MODE_RAW);
        send_item(OP_LOOKUP, 24'h000041, MODE_RAW);
    endtask

    task automatic test_random_traffic();
        idle_on = 1'b1;
        run_random(150, 1'b1);
        write_sector_count(SECTOR_W'($urandom_range(24'hFFFFFF, 1)));
        // long stretch with no idling on either side
        idle_on = 1'b0;
        run_random(150, 1'b1);
        idle_on = 1'b1;
        write_sector_count(SECTOR_W'($urandom_range(4096, 1)));
        run_random(80, 1'b1);
        write_sector_count(24'h000001);
        run_random(20, 1'b0);
    endtask

    task automatic test_backpressure();
        write_sector_count(24'h800000);
        hold_left = 80;
        run_random(20, 1'b0);
    endtask

    task automatic test_drain_pause();
        write_sector_count(24'h000000);
        run_random(10, 1'b0);
        drop_req();
        wait_drain();
        write_sector_count(24'hFFFFFF);
        run_random(10, 1'b0);
    endtask

    // Response side: random stalls plus a counted hold-off
    initial begin
        rsp_if.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_if.ready = 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready = !(idle_on && $urandom_range(99) < 6);
            end
        end
    end

    always @(posedge i_clk) begin
        t_tag_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no pending request");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (rsp_if.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
                    fail_count++;
                end
                if (rsp_if.hit !== want.hit) begin
                    $error("hit: expected %0d, actual %0d", want.hit, rsp_if.hit);
                    fail_count++;
                end
                if (rsp_if.entry_index !== want.entry_index) begin
                    $error("entry_index: expected 0x%0h, actual 0x%0h",
                           want.entry_index, rsp_if.entry_index);
                    fail_count++;
                end
                if (rsp_if.block_start !== want.block_start) begin
                    $error("block_start: expected 0x%0h, actual 0x%0h",
                           want.block_start, rsp_if.block_start);
                    fail_count++;
                end
                if (rsp_if.byte_offset !== want.byte_offset) begin
                    $error("byte_offset: expected %0d, actual %0d",
                           want.byte_offset, rsp_if.byte_offset);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("sector_block_cache_tag_store_top test failed");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_if.valid     = 1'b0;
        req_if.op        = OP_LOOKUP;
        req_if.sector    = '0;
        req_if.read_mode = MODE_RAW;
        disc_sectors     = '0;
        idle_on          = 1'b1;
        hold_left        = 0;
        inval_budget     = 10;
        for (int e = 0; e < ENTRIES; e++) shadow_valid[e] = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_beyond_at_zero_count();
        test_offsets_and_hits();
        test_disc_end();
        test_index_collision();
        test_invalidate_and_ignored_op();
        test_random_traffic();
        test_backpressure();
        test_drain_pause();

        drop_req();
        wait_drain();
        repeat (10) @(posedge i_clk);
        $display("checked %0d result beats: %0d lookups (%0d hits, %0d past disc end),",
                 n_checked, n_lookup, n_hit, n_beyond);
        $display("%0d tag updates, %0d invalidates, sector_count from 0 to max",
                 n_update, n_inval);
        if (fail_count == 0) begin
            $display("sector_block_cache_tag_store_top test passed");
        end else begin
            $display("sector_block_cache_tag_store_top test failed");
        end
        $finish;
    end

endmodule
